>>> hdl/tga_pkg.sv
package tga_pkg;

  // Default configuration
  localparam int unsigned NUM_SLOTS_DEF       = 1024;
  localparam int unsigned SLOT_FIELD_BITS_DEF = 20;

  // Fixed field widths
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_LOOKUP   = 2'd2,
    KIND_COMPLETE = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_HELD      = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_EXEC = 1'b1
  } seq_state_e;

  // Memory strobes from sequencer to the stores
  typedef struct packed {
    logic rd_en;     // read slot table and stack top
    logic slot_we;   // write slot table entry
    logic stack_we;  // push onto free stack
  } mem_ctl_t;

endpackage

>>> hdl/tga_store.sv
module tga_store #(
  parameter int unsigned NUM_SLOTS = tga_pkg::NUM_SLOTS_DEF,
  parameter int unsigned AW        = $clog2(NUM_SLOTS)
) (
  input  logic                          clk_i,
  input  tga_pkg::mem_ctl_t             ctl_i,
  input  logic [AW-1:0]                 slot_raddr_i,
  input  logic [AW-1:0]                 slot_waddr_i,
  input  logic [tga_pkg::HANDLE_W:0]    slot_wdata_i,
  output logic [tga_pkg::HANDLE_W:0]    slot_rdata_o,
  input  logic [AW-1:0]                 stack_raddr_i,
  input  logic [AW-1:0]                 stack_waddr_i,
  input  logic [tga_pkg::HANDLE_W-1:0]  stack_wdata_i,
  output logic [tga_pkg::HANDLE_W-1:0]  stack_rdata_o
);

  // Slot table: {used, handle} per slot
  logic [tga_pkg::HANDLE_W:0]   slot_mem [NUM_SLOTS];
  // Free stack of released handles
  logic [tga_pkg::HANDLE_W-1:0] stack_mem [NUM_SLOTS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.slot_we) begin
      slot_mem[slot_waddr_i] <= slot_wdata_i;
    end
    if (ctl_i.rd_en) begin
      slot_rdata_o <= slot_mem[slot_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.stack_we) begin
      stack_mem[stack_waddr_i] <= stack_wdata_i;
    end
    if (ctl_i.rd_en) begin
      stack_rdata_o <= stack_mem[stack_raddr_i];
    end
  end

endmodule

>>> hdl/tga_ctrl.sv
module tga_ctrl #(
  parameter int unsigned NUM_SLOTS       = tga_pkg::NUM_SLOTS_DEF,
  parameter int unsigned SLOT_FIELD_BITS = tga_pkg::SLOT_FIELD_BITS_DEF,
  parameter int unsigned AW              = $clog2(NUM_SLOTS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tga_pkg::KIND_W-1:0]    kind_i,
  input  logic [tga_pkg::HANDLE_W-1:0]  handle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tga_pkg::HANDLE_W-1:0]  result_handle_o,
  output logic [tga_pkg::STATUS_W-1:0]  status_o,
  output tga_pkg::mem_ctl_t             ctl_o,
  output logic [AW-1:0]                 slot_raddr_o,
  output logic [AW-1:0]                 slot_waddr_o,
  output logic [tga_pkg::HANDLE_W:0]    slot_wdata_o,
  input  logic [tga_pkg::HANDLE_W:0]    slot_rdata_i,
  output logic [AW-1:0]                 stack_raddr_o,
  output logic [AW-1:0]                 stack_waddr_o,
  output logic [tga_pkg::HANDLE_W-1:0]  stack_wdata_o,
  input  logic [tga_pkg::HANDLE_W-1:0]  stack_rdata_i
);

  localparam int unsigned HW          = tga_pkg::HANDLE_W;
  localparam longint unsigned SLOT_SPAN = 64'd1 << SLOT_FIELD_BITS;
  localparam longint unsigned FRESH_LIMIT =
    (64'(NUM_SLOTS) < SLOT_SPAN) ? 64'(NUM_SLOTS) : SLOT_SPAN;
  localparam int unsigned FW          = $clog2(FRESH_LIMIT + 1);
  localparam int unsigned CW          = $clog2(NUM_SLOTS + 1);
  localparam logic [HW-1:0] GEN_STEP  = HW'(SLOT_SPAN);

  tga_pkg::seq_state_e state_q, state_d;

  logic [tga_pkg::KIND_W-1:0] kind_q;
  logic [HW-1:0]              hdl_q;
  logic [FW-1:0]              fresh_q, fresh_d;
  logic [CW-1:0]              free_cnt_q, free_cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic [HW-1:0]              result_q, result_d;
  tga_pkg::status_e           status_q, status_d;

  logic                       in_xfer;
  logic                       go;
  logic [SLOT_FIELD_BITS-1:0] req_slot;
  logic [SLOT_FIELD_BITS-1:0] in_slot;
  logic                       live;
  logic [HW-1:0]              bumped;

  assign in_ready_o = (state_q == tga_pkg::SEQ_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  // Execute step waits until the output register is free
  assign go         = (state_q == tga_pkg::SEQ_EXEC) && (!out_valid_q || out_ready_i);

  assign in_slot  = handle_i[SLOT_FIELD_BITS-1:0];
  assign req_slot = hdl_q[SLOT_FIELD_BITS-1:0];

  // Reads issued on the input transfer, data ready in the execute step
  assign slot_raddr_o  = AW'(in_slot);
  assign stack_raddr_o = AW'(free_cnt_q - CW'(1));

  // Shared match unit: slot handed out, occupied and stored handle equal
  assign live = (req_slot != '0)
             && (32'(req_slot) < 32'(fresh_q))
             && slot_rdata_i[HW]
             && (slot_rdata_i[HW-1:0] == hdl_q);

  assign bumped = stack_rdata_i + GEN_STEP;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tga_pkg::SEQ_IDLE: if (in_xfer) state_d = tga_pkg::SEQ_EXEC;
      tga_pkg::SEQ_EXEC: if (go)      state_d = tga_pkg::SEQ_IDLE;
      default:                        state_d = tga_pkg::SEQ_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    ctl_o         = '0;
    ctl_o.rd_en   = in_xfer;
    slot_waddr_o  = AW'(req_slot);
    slot_wdata_o  = {1'b0, hdl_q};
    stack_waddr_o = AW'(free_cnt_q);
    stack_wdata_o = hdl_q;
    fresh_d       = fresh_q;
    free_cnt_d    = free_cnt_q;
    result_d      = result_q;
    status_d      = status_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    unique case (state_q)
      tga_pkg::SEQ_IDLE: begin
      end
      tga_pkg::SEQ_EXEC: begin
        if (go) begin
          out_valid_d = 1'b1;
          result_d    = '0;
          status_d    = tga_pkg::STAT_OK;
          if (tga_pkg::kind_e'(kind_q) == tga_pkg::KIND_ALLOC) begin
            if (hdl_q != '0) begin
              status_d = tga_pkg::STAT_HELD;
            end else if (free_cnt_q != '0) begin
              // Reuse top of free stack with next generation
              free_cnt_d    = free_cnt_q - CW'(1);
              ctl_o.slot_we = 1'b1;
              slot_waddr_o  = AW'(bumped[SLOT_FIELD_BITS-1:0]);
              slot_wdata_o  = {1'b1, bumped};
              result_d      = bumped;
            end else if (64'(fresh_q) < FRESH_LIMIT) begin
              // Never-used slot, generation zero
              fresh_d       = fresh_q + FW'(1);
              ctl_o.slot_we = 1'b1;
              slot_waddr_o  = AW'(fresh_q);
              slot_wdata_o  = {1'b1, HW'(fresh_q)};
              result_d      = HW'(fresh_q);
            end else begin
              status_d = tga_pkg::STAT_FULL;
            end
          end else if (live) begin
            result_d = hdl_q;
            if (tga_pkg::kind_e'(kind_q) != tga_pkg::KIND_LOOKUP) begin
              // Release or complete: clear occupancy, push handle if the stack has room
              ctl_o.slot_we = 1'b1;
              if (32'(free_cnt_q) < 32'(NUM_SLOTS)) begin
                ctl_o.stack_we = 1'b1;
                free_cnt_d     = free_cnt_q + CW'(1);
              end
            end
          end else begin
            status_d = tga_pkg::STAT_NOT_FOUND;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tga_pkg::SEQ_IDLE;
      fresh_q     <= FW'(1);
      free_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fresh_q     <= fresh_d;
      free_cnt_q  <= free_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= kind_i;
      hdl_q  <= handle_i;
    end
    result_q <= result_d;
    status_q <= status_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_handle_o = result_q;
  assign status_o        = status_q;

endmodule

>>> hdl/generational_request_tag_allocator.sv
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_ready_o  kind_i[1:0], handle_i[31:0]
// result    out        out_valid_o/out_ready_i result_handle_o[31:0], status_o[1:0]
//
// Each request has a read step on the slot table and free stack (registered
// memory reads) and an update step that compares, updates the stores and loads
// the output register. A result waiting in the output register does not block
// the next request's read step; the update step waits only while the output
// register holds a result that is not taken in that same cycle. Reset is
// asynchronous, active low, and needs no clearing pass: the fresh-slot and
// free-stack counters gate every read.
module generational_request_tag_allocator #(
  parameter int unsigned NUM_SLOTS       = tga_pkg::NUM_SLOTS_DEF,
  parameter int unsigned SLOT_FIELD_BITS = tga_pkg::SLOT_FIELD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tga_pkg::KIND_W-1:0]    kind_i,
  input  logic [tga_pkg::HANDLE_W-1:0]  handle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tga_pkg::HANDLE_W-1:0]  result_handle_o,
  output logic [tga_pkg::STATUS_W-1:0]  status_o
);

  localparam int unsigned AW = $clog2(NUM_SLOTS);

  tga_pkg::mem_ctl_t             ctl;
  logic [AW-1:0]                 slot_raddr;
  logic [AW-1:0]                 slot_waddr;
  logic [tga_pkg::HANDLE_W:0]    slot_wdata;
  logic [tga_pkg::HANDLE_W:0]    slot_rdata;
  logic [AW-1:0]                 stack_raddr;
  logic [AW-1:0]                 stack_waddr;
  logic [tga_pkg::HANDLE_W-1:0]  stack_wdata;
  logic [tga_pkg::HANDLE_W-1:0]  stack_rdata;

  // Sequencer and match unit
  tga_ctrl #(
    .NUM_SLOTS       (NUM_SLOTS),
    .SLOT_FIELD_BITS (SLOT_FIELD_BITS),
    .AW              (AW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .handle_i        (handle_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_handle_o (result_handle_o),
    .status_o        (status_o),
    .ctl_o           (ctl),
    .slot_raddr_o    (slot_raddr),
    .slot_waddr_o    (slot_waddr),
    .slot_wdata_o    (slot_wdata),
    .slot_rdata_i    (slot_rdata),
    .stack_raddr_o   (stack_raddr),
    .stack_waddr_o   (stack_waddr),
    .stack_wdata_o   (stack_wdata),
    .stack_rdata_i   (stack_rdata)
  );

  // Slot table and free stack
  tga_store #(
    .NUM_SLOTS (NUM_SLOTS),
    .AW        (AW)
  ) u_store (
    .clk_i         (clk_i),
    .ctl_i         (ctl),
    .slot_raddr_i  (slot_raddr),
    .slot_waddr_i  (slot_waddr),
    .slot_wdata_i  (slot_wdata),
    .slot_rdata_o  (slot_rdata),
    .stack_raddr_i (stack_raddr),
    .stack_waddr_i (stack_waddr),
    .stack_wdata_i (stack_wdata),
    .stack_rdata_o (stack_rdata)
  );

endmodule

>>> sim/tga_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the tag allocator, keeps a shadow of the slot table
// and free stack, and compares every result transfer with the oldest prediction.
module tga_result_checker #(
  parameter int unsigned NUM_SLOTS       = tga_pkg::NUM_SLOTS_DEF,
  parameter int unsigned SLOT_FIELD_BITS = tga_pkg::SLOT_FIELD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [tga_pkg::KIND_W-1:0]   kind_i,
  input  logic [tga_pkg::HANDLE_W-1:0] handle_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [tga_pkg::HANDLE_W-1:0] result_handle_i,
  input  logic [tga_pkg::STATUS_W-1:0] status_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  localparam logic [tga_pkg::HANDLE_W-1:0] SLOT_MASK =
    (32'd1 << SLOT_FIELD_BITS) - 32'd1;
  localparam logic [tga_pkg::HANDLE_W-1:0] GEN_STEP  = 32'd1 << SLOT_FIELD_BITS;
  localparam longint unsigned FRESH_LIMIT =
    (NUM_SLOTS < (64'd1 << SLOT_FIELD_BITS)) ? NUM_SLOTS : (64'd1 << SLOT_FIELD_BITS);

  typedef struct {
    logic [tga_pkg::HANDLE_W-1:0] handle;
    tga_pkg::status_e             status;
  } tag_result_t;

  // Shadow of the allocator state
  logic [tga_pkg::HANDLE_W-1:0] shadow_handle [NUM_SLOTS];
  bit                           shadow_used   [NUM_SLOTS];
  logic [tga_pkg::HANDLE_W-1:0] shadow_stack  [NUM_SLOTS];
  longint unsigned              fresh_slot;
  longint unsigned              stack_depth;

  tag_result_t expected_results[$];

  // Applies one request to the shadow state and returns the answer it should get
  function automatic tag_result_t predict_tag_result(tga_pkg::kind_e kind,
                                                     logic [tga_pkg::HANDLE_W-1:0] handle);
    tag_result_t                  res;
    logic [tga_pkg::HANDLE_W-1:0] bumped;
    longint unsigned              slot;
    res.handle = '0;
    res.status = tga_pkg::STAT_OK;
    if (kind == tga_pkg::KIND_ALLOC) begin
      if (handle != '0) begin
        res.status = tga_pkg::STAT_HELD;
      end else if (stack_depth > 0) begin
        // pop and bump generation, wrap comes from the 32-bit add
        stack_depth--;
        bumped = shadow_stack[stack_depth] + GEN_STEP;
        slot   = bumped & SLOT_MASK;
        if (slot < NUM_SLOTS) begin
          shadow_handle[slot] = bumped;
          shadow_used[slot]   = 1'b1;
          res.handle          = bumped;
        end else begin
          res.status = tga_pkg::STAT_FULL;
        end
      end else if (fresh_slot < FRESH_LIMIT) begin
        shadow_handle[fresh_slot] = tga_pkg::HANDLE_W'(fresh_slot);
        shadow_used[fresh_slot]   = 1'b1;
        res.handle                = tga_pkg::HANDLE_W'(fresh_slot);
        fresh_slot++;
      end else begin
        res.status = tga_pkg::STAT_FULL;
      end
    end else begin
      slot = handle & SLOT_MASK;
      if (slot != 0 && slot < fresh_slot && slot < NUM_SLOTS &&
          shadow_used[slot] && shadow_handle[slot] == handle) begin
        res.handle = handle;
        if (kind != tga_pkg::KIND_LOOKUP) begin
          shadow_used[slot] = 1'b0;
          if (stack_depth < NUM_SLOTS) begin
            shadow_stack[stack_depth] = handle;
            stack_depth++;
          end
        end
      end else begin
        res.status = tga_pkg::STAT_NOT_FOUND;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tag_result_t want;
    tag_result_t pred;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        shadow_used[i] = 1'b0;
      end
      fresh_slot   = 1;
      stack_depth  = 0;
      fail_count_o = 0;
      expected_results.delete();
    end else begin
      // request transfer: predict
      if (in_valid_i && in_ready_i) begin
        pred = predict_tag_result(tga_pkg::kind_e'(kind_i), handle_i);
        expected_results.insert(expected_results.size(), pred);
      end
      // result transfer: compare with oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing pending: result_handle %h status %0d",
                 result_handle_i, status_i);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (result_handle_i !== want.handle) begin
            $error("result_handle: expected %h, actual %h", want.handle, result_handle_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

>>> sim/generational_request_tag_allocator_tb.sv
`timescale 1ns / 1ps

module generational_request_tag_allocator_tb;

  localparam int unsigned NUM_SLOTS       = tga_pkg::NUM_SLOTS_DEF;
  localparam int unsigned SLOT_FIELD_BITS = tga_pkg::SLOT_FIELD_BITS_DEF;
  localparam logic [tga_pkg::HANDLE_W-1:0] GEN_STEP = 32'd1 << SLOT_FIELD_BITS;
  localparam int IDLE_LIMIT   = 2000;
  localparam int WRAP_ROUNDS  = 40;
  localparam int CHURN_ITEMS  = 100;
  localparam int FILL_CAP     = 1100;
  localparam int DRAIN_ITEMS  = 120;
  localparam int POOL_DEPTH   = 2048;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  tga_pkg::kind_e               kind = tga_pkg::KIND_ALLOC;
  logic [tga_pkg::HANDLE_W-1:0] handle = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [tga_pkg::HANDLE_W-1:0] result_handle;
  logic [tga_pkg::STATUS_W-1:0] status;
  int                           fail_count;
  int                           pending;

  bit                           no_idle = 1'b0;
  bit                           seen_full = 1'b0;
  int                           sent_count = 0;
  logic [tga_pkg::HANDLE_W-1:0] seen_handles[$];

  // Clock and reset
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  generational_request_tag_allocator #(
    .NUM_SLOTS      (NUM_SLOTS),
    .SLOT_FIELD_BITS(SLOT_FIELD_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .handle_i       (handle),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_handle_o(result_handle),
    .status_o       (status)
  );

  tga_result_checker #(
    .NUM_SLOTS      (NUM_SLOTS),
    .SLOT_FIELD_BITS(SLOT_FIELD_BITS)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .kind_i         (kind),
    .handle_i       (handle),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_handle_i(result_handle),
    .status_i       (status),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Collect handles from good results so requests can aim at live and stale ones
  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      if (status == tga_pkg::STAT_OK) begin
        seen_handles.insert(seen_handles.size(), result_handle);
        if (seen_handles.size() > POOL_DEPTH) void'(seen_handles.pop_front());
      end
      if (status == tga_pkg::STAT_FULL) seen_full = 1'b1;
    end
  end

  // Pick a handle: mostly one seen before, some with a flipped bit, some random
  function automatic logic [tga_pkg::HANDLE_W-1:0] pick_handle();
    int roll;
    logic [tga_pkg::HANDLE_W-1:0] h;
    roll = $urandom_range(0, 99);
    if (seen_handles.size() == 0 || roll < 15) return $urandom;
    h = seen_handles[$urandom_range(0, seen_handles.size() - 1)];
    if (roll < 30) h = h ^ (32'd1 << $urandom_range(0, tga_pkg::HANDLE_W - 1));
    return h;
  endfunction

  // One request transfer, with a random gap ahead of it
  task automatic send_req(tga_pkg::kind_e k, logic [tga_pkg::HANDLE_W-1:0] h);
    int gap;
    if (sent_count % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
    sent_count++;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= k;
    handle   <= h;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_noise();
    send_req(tga_pkg::kind_e'($urandom_range(0, 3)),
             ($urandom_range(0, 3) == 0) ? '0 : $urandom);
  endtask

  // Result side: random stall before each transfer
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus
  initial begin
    logic [tga_pkg::HANDLE_W-1:0] wrap_h;
    int roll;
    int fill_n;
    wait (rst_ni);
    @(posedge clk_i);

    // directed: fresh slots, held requester, misses, stale generation, LIFO reuse
    send_req(tga_pkg::KIND_ALLOC, '0);
    send_req(tga_pkg::KIND_ALLOC, '0);
    send_req(tga_pkg::KIND_ALLOC, '0);
    send_req(tga_pkg::KIND_ALLOC, 32'hFFFF_FFFF);
    send_req(tga_pkg::KIND_ALLOC, 32'h0000_0001);
    send_req(tga_pkg::KIND_LOOKUP, 32'h0000_0001);
    send_req(tga_pkg::KIND_LOOKUP, 32'h0000_0000);
    send_req(tga_pkg::KIND_LOOKUP, 32'hFFFF_FFFF);
    send_req(tga_pkg::KIND_LOOKUP, 32'h0000_0005);
    send_req(tga_pkg::KIND_RELEASE, 32'h0000_0002);
    send_req(tga_pkg::KIND_RELEASE, 32'h0000_0002);
    send_req(tga_pkg::KIND_LOOKUP, 32'h0000_0002);
    send_req(tga_pkg::KIND_ALLOC, '0);
    send_req(tga_pkg::KIND_LOOKUP, 32'h0000_0002);
    send_req(tga_pkg::KIND_LOOKUP, 32'h0010_0002);
    send_req(tga_pkg::KIND_COMPLETE, 32'h0010_0002);
    send_req(tga_pkg::KIND_COMPLETE, 32'h0010_0002);
    send_req(tga_pkg::KIND_COMPLETE, 32'h0000_0003);
    send_req(tga_pkg::KIND_RELEASE, 32'h0000_0001);
    send_req(tga_pkg::KIND_ALLOC, '0);
    send_req(tga_pkg::KIND_ALLOC, '0);
    send_req(tga_pkg::KIND_ALLOC, '0);
    send_req(tga_pkg::KIND_LOOKUP, 32'h8000_0003);

    // generation bumps: release and reallocate the same slot over and over
    wrap_h = 32'h0020_0002;
    repeat (WRAP_ROUNDS) begin
      send_req(tga_pkg::KIND_RELEASE, wrap_h);
      send_req(tga_pkg::KIND_ALLOC, '0);
      wrap_h = wrap_h + GEN_STEP;
    end
    send_req(tga_pkg::KIND_LOOKUP, wrap_h);

    // churn with mixed kinds
    repeat (CHURN_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) send_req(tga_pkg::KIND_ALLOC, '0);
      else if (roll < 55) send_req(tga_pkg::KIND_RELEASE, pick_handle());
      else if (roll < 70) send_req(tga_pkg::KIND_LOOKUP, pick_handle());
      else if (roll < 85) send_req(tga_pkg::KIND_COMPLETE, pick_handle());
      else send_noise();
    end

    // fill the table until it reports full or FILL_CAP requests have been sent
    fill_n = 0;
    while (!seen_full && fill_n < FILL_CAP) begin
      if ($urandom_range(0, 19) == 0) send_req(tga_pkg::KIND_LOOKUP, pick_handle());
      else send_req(tga_pkg::KIND_ALLOC, '0);
      fill_n++;
    end

    // drain and reuse from a full table
    repeat (DRAIN_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) send_req(tga_pkg::KIND_ALLOC, '0);
      else if (roll < 55) send_req(tga_pkg::KIND_RELEASE, pick_handle());
      else if (roll < 80) send_req(tga_pkg::KIND_COMPLETE, pick_handle());
      else if (roll < 90) send_req(tga_pkg::KIND_LOOKUP, pick_handle());
      else send_noise();
    end
    in_valid <= 1'b0;

    // let the checker count the last transfer before polling pending
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> generational_request_tag_allocator.f
hdl/tga_pkg.sv
hdl/tga_store.sv
hdl/tga_ctrl.sv
hdl/generational_request_tag_allocator.sv
sim/tga_result_checker.sv
sim/generational_request_tag_allocator_tb.sv
